/* design/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, codes and types of the five-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int LEVELS     = 5;
    localparam int IDX_W      = 9;
    localparam int FRAME_SH   = 12;
    localparam int ENTRY_W    = 64;
    localparam int VPN_W      = 45;
    localparam int PPN_W      = 52;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam int ROOT_W     = 6;
    localparam int FREE_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ADDR_W     = FRAME_W + IDX_W;
    localparam int DEPTH      = NUM_FRAMES * (2 ** IDX_W);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int SUM_W      = ((FREE_W > CNT_W) ? FREE_W : CNT_W) + 1;
    localparam int LEVEL_W    = $clog2(LEVELS);

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MAP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FRAMES = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        addr_t  raddr;
    } ram_req_t;

endpackage

`default_nettype wire

/* design/ptw_if.sv */
// ----------------------------------------------------------------------------
// ptw_req_if / ptw_rsp_if
// Valid/ready channels for walk requests and walk responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptw_req_if;
    logic                        valid;
    logic                        ready;
    logic [ptw_pkg::OP_W-1:0]    operation;
    logic [ptw_pkg::VPN_W-1:0]   virtual_page;
    logic [ptw_pkg::PPN_W-1:0]   new_ppn;

    modport source (output valid, output operation, output virtual_page, output new_ppn,
                    input ready);
    modport sink   (input valid, input operation, input virtual_page, input new_ppn,
                    output ready);
endinterface

interface ptw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ptw_pkg::STATUS_W-1:0] status;
    logic [ptw_pkg::PPN_W-1:0]    found_ppn;

    modport source (output valid, output status, output found_ppn, input ready);
    modport sink   (input valid, input status, input found_ppn, output ready);
endinterface

`default_nettype wire

/* design/ptw_frame_ram.sv */
// ----------------------------------------------------------------------------
// ptw_frame_ram
// Frame memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_frame_ram (
    input  wire logic              clk,
    input  wire ptw_pkg::ram_req_t ram_req,
    output ptw_pkg::entry_t        rdata
);
    import ptw_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        rdata <= mem[ram_req.raddr];
    end

endmodule

`default_nettype wire

/* design/ptw_walker.sv */
// ----------------------------------------------------------------------------
// ptw_walker
// Walk sequencer: clearing pass, level reads, frame allocation, leaf update.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_walker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [ptw_pkg::ROOT_W-1:0]     root_frame,
    input  wire logic [ptw_pkg::FREE_W-1:0]     first_free_frame,
    ptw_req_if.sink                             req,
    ptw_rsp_if.source                           rsp,
    output ptw_pkg::ram_req_t                   ram_req,
    input  wire ptw_pkg::entry_t                rdata
);
    import ptw_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]          state_reg, state_next;
    addr_t               clr_reg, clr_next;
    logic [CNT_W-1:0]    alloc_reg, alloc_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [VPN_W-1:0]    vpn_reg, vpn_next;
    logic [PPN_W-1:0]    ppn_reg, ppn_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PPN_W-1:0]    found_reg, found_next;

    logic [IDX_W-1:0]    idx;
    addr_t               walk_addr;
    logic [SUM_W-1:0]    fresh;
    logic                fresh_ok;
    logic [PPN_W-1:0]    pte_frame;
    logic                out_free;

    assign idx       = vpn_reg[IDX_W * (LEVELS - 1 - int'(level_reg)) +: IDX_W];
    assign walk_addr = {frame_reg, idx};
    assign fresh     = SUM_W'(first_free_frame) + SUM_W'(alloc_reg);
    assign fresh_ok  = fresh < SUM_W'(NUM_FRAMES);
    assign pte_frame = rdata[FRAME_SH +: PPN_W];
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready     = (state_reg == S_IDLE) && out_free;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.found_ppn = found_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        alloc_next     = alloc_reg;
        level_next     = level_reg;
        frame_next     = frame_reg;
        op_next        = op_reg;
        vpn_next       = vpn_reg;
        ppn_next       = ppn_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        found_next     = found_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = walk_addr;
        ram_req.wdata  = '0;
        ram_req.raddr  = walk_addr;

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    op_next    = req.operation;
                    vpn_next   = req.virtual_page;
                    ppn_next   = req.new_ppn;
                    level_next = '0;
                    frame_next = FRAME_W'(root_frame);
                    if (!(req.operation inside {OP_QUERY, OP_MAP, OP_UNMAP}) ||
                        32'(root_frame) >= 32'(NUM_FRAMES))
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_MAP;
                        found_next     = '0;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (level_reg == LEVEL_W'(LEVELS - 1))
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    found_next     = '0;
                    case (op_reg)
                        OP_QUERY:
                        begin
                            if (rdata[0])
                            begin
                                found_next = pte_frame;
                            end
                            else
                            begin
                                status_next = ST_NO_MAP;
                            end
                        end
                        OP_MAP:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = {ppn_reg, {(FRAME_SH-1){1'b0}}, 1'b1};
                        end
                        default:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = '0;
                        end
                    endcase
                end
                else if (rdata[0])
                begin
                    if (pte_frame >= PPN_W'(NUM_FRAMES))
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_MAP;
                        found_next     = '0;
                    end
                    else
                    begin
                        frame_next = pte_frame[FRAME_W-1:0];
                        level_next = level_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
                else if (op_reg == OP_MAP)
                begin
                    if (fresh_ok)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = {ENTRY_W'(fresh[FRAME_W-1:0]) << FRAME_SH} |
                                        ENTRY_W'(1);
                        alloc_next    = alloc_reg + 1'b1;
                        frame_next    = fresh[FRAME_W-1:0];
                        level_next    = level_reg + 1'b1;
                        state_next    = S_ISSUE;
                    end
                    else
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_FRAMES;
                        found_next     = '0;
                    end
                end
                else
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_NO_MAP;
                    found_next     = '0;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg  <= level_next;
        frame_reg  <= frame_next;
        op_reg     <= op_next;
        vpn_reg    <= vpn_next;
        ppn_reg    <= ppn_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

`default_nettype wire

/* design/five_level_page_table_walker.sv */
// ----------------------------------------------------------------------------
// five_level_page_table_walker
// Five-level, 9-bit radix page table walker with an on-block frame memory.
//
// req carries one transaction per walk: operation (query, map, unmap), a
// 45-bit virtual page and, for map, the physical page to install. rsp returns
// one transaction per request: status and, for a successful query, the
// physical page. A request is taken only when idle and no response is
// pending or the pending one is being taken. Each level has an issue state,
// which addresses the single frame memory, and a check state, which sees
// its registered read data; an unused operation or an out-of-range root
// is answered from the idle state without a walk.
// After reset the block clears the frame memory one entry a cycle, all
// NUM_FRAMES*512 entries (32768); req.ready stays low until it is done.
// Configuration writes (root_frame, first_free_frame) are taken at any time
// through cfg_we/cfg_index/cfg_data. When rsp.ready is low the response
// holds in its output register and no new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module five_level_page_table_walker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ptw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ptw_pkg::CFG_DATA_W-1:0] cfg_data,
    ptw_req_if.sink                             req,
    ptw_rsp_if.source                           rsp
);
    import ptw_pkg::*;

    logic [ROOT_W-1:0] root_reg;
    logic [FREE_W-1:0] free_reg;
    ram_req_t          ram_req;
    entry_t            rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            free_reg <= FREE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROOT_FRAME: root_reg <= cfg_data[ROOT_W-1:0];
                CFG_FIRST_FREE: free_reg <= cfg_data[FREE_W-1:0];
                default:        root_reg <= root_reg;
            endcase
        end
    end

    ptw_walker u_walker (
        .clk              (clk),
        .rst_n            (rst_n),
        .root_frame       (root_reg),
        .first_free_frame (free_reg),
        .req              (req),
        .rsp              (rsp),
        .ram_req          (ram_req),
        .rdata            (rdata)
    );

    ptw_frame_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

endmodule

`default_nettype wire

/* test/five_level_page_table_walker_tb.sv */
// ----------------------------------------------------------------------------
// five_level_page_table_walker_tb
// Self-checking testbench: directed walks cover empty and present paths,
// table allocation up to frame exhaustion, out-of-range frames and the unused
// opcode; random phases follow with varying root/allocator settings and
// randomized valid/ready idling. A local page table model predicts each
// response transaction and the monitor compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module five_level_page_table_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WALKS   = 235;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
    } walk_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PPN_W-1:0]    ppn;
    } walk_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptw_req_if req_ch ();
    ptw_rsp_if rsp_ch ();

    five_level_page_table_walker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // page table model
    logic [ENTRY_W-1:0] page_mem [DEPTH];
    logic [6:0]         alloc_count;
    logic [ROOT_W-1:0]  root_cfg;
    logic [FREE_W-1:0]  free_cfg;

    walk_req_t        pending_walks [$];
    walk_rsp_t        expected_rsps [$];
    logic [VPN_W-1:0] known_vpns [$];

    bit          req_busy = 1'b0;
    bit          idle_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned rsp_stall = 0;
    int          errors = 0;
    int          n_found = 0;
    int          n_miss = 0;
    int          n_no_frames = 0;

    function automatic walk_rsp_t predict_walk(walk_req_t w);
        walk_rsp_t          r;
        logic [PPN_W-1:0]   frame;
        logic [ENTRY_W-1:0] pte;
        logic [7:0]         fresh;
        addr_t              slot;
        r.status = ST_NO_MAP;
        r.ppn    = '0;
        frame    = PPN_W'(root_cfg);
        if (w.op == OP_UNUSED)
            return r;
        for (int lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            slot = {frame[FRAME_W-1:0], w.vpn[IDX_W*(LEVELS-1-lvl) +: IDX_W]};
            pte  = page_mem[slot];
            if (pte[0])
            begin
                frame = pte[ENTRY_W-1:FRAME_SH];
                if (frame >= NUM_FRAMES)
                    return r;
            end
            else if (w.op == OP_MAP)
            begin
                fresh = 8'(free_cfg) + 8'(alloc_count);
                if (fresh >= NUM_FRAMES)
                begin
                    r.status = ST_NO_FRAMES;
                    return r;
                end
                alloc_count++;
                page_mem[slot] = {PPN_W'(fresh), {(FRAME_SH-1){1'b0}}, 1'b1};
                frame = PPN_W'(fresh);
            end
            else
                return r;
        end
        slot = {frame[FRAME_W-1:0], w.vpn[IDX_W-1:0]};
        pte  = page_mem[slot];
        case (w.op)
            OP_QUERY:
                if (pte[0])
                begin
                    r.status = ST_OK;
                    r.ppn    = pte[ENTRY_W-1:FRAME_SH];
                end
            OP_MAP:
            begin
                page_mem[slot] = {w.ppn, {(FRAME_SH-1){1'b0}}, 1'b1};
                r.status = ST_OK;
            end
            default:
            begin
                page_mem[slot] = '0;
                r.status = ST_OK;
            end
        endcase
        return r;
    endfunction

    task automatic push_walk(logic [OP_W-1:0] op, logic [VPN_W-1:0] vpn,
                             logic [PPN_W-1:0] ppn);
        walk_req_t w;
        w.op  = op;
        w.vpn = vpn;
        w.ppn = ppn;
        pending_walks.push_back(w);
        if (op == OP_MAP)
            known_vpns.push_back(vpn);
    endtask

    task automatic queue_random_walks(int count);
        int unsigned      roll;
        logic [OP_W-1:0]  op;
        logic [VPN_W-1:0] vpn;
        logic [PPN_W-1:0] ppn;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            op = (roll < 45) ? OP_QUERY : (roll < 75) ? OP_MAP :
                 (roll < 95) ? OP_UNMAP : OP_UNUSED;
            roll = $urandom_range(0, 99);
            if (known_vpns.size() == 0 || roll < 10)
                vpn = VPN_W'({$urandom, $urandom});
            else
            begin
                vpn = known_vpns[$urandom_range(0, known_vpns.size() - 1)];
                if (roll < 50)
                    vpn[IDX_W-1:0] = IDX_W'($urandom);
                else if (roll < 58)
                    vpn[2*IDX_W-1:0] = (2*IDX_W)'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 30)
                ppn = PPN_W'($urandom_range(0, NUM_FRAMES - 1));
            else if (roll < 35)
                ppn = '1;
            else
                ppn = PPN_W'({$urandom, $urandom});
            push_walk(op, vpn, ppn);
        end
    endtask

    task automatic drain();
        while (pending_walks.size() != 0 || req_busy || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    // called at a falling edge with the block idle
    task automatic set_walk_config(logic [ROOT_W-1:0] root, logic [FREE_W-1:0] first_free);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROOT_FRAME;
        cfg_data  <= CFG_DATA_W'(root);
        @(negedge clk);
        cfg_index <= CFG_FIRST_FREE;
        cfg_data  <= CFG_DATA_W'(first_free);
        @(negedge clk);
        cfg_we   <= 1'b0;
        root_cfg  = root;
        free_cfg  = first_free;
        @(posedge clk);
    endtask

    always @(negedge clk)
    begin : driver
        walk_req_t w;
        if (rst_n)
        begin
            if (!req_busy)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_walks.size() != 0)
                begin
                    w = pending_walks.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.operation    <= w.op;
                    req_ch.virtual_page <= w.vpn;
                    req_ch.new_ppn      <= w.ppn;
                    req_busy = 1'b1;
                    send_gap = idle_on ? $urandom_range(0, 7) : 0;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            if (rsp_stall != 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        walk_req_t w;
        walk_rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response transaction: status %0d found_ppn 0x%0h",
                       rsp_ch.status, rsp_ch.found_ppn);
                errors++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.found_ppn !== want.ppn)
                begin
                    $error("found_ppn: expected 0x%0h, got 0x%0h", want.ppn, rsp_ch.found_ppn);
                    errors++;
                end
                case (want.status)
                    ST_OK:        n_found++;
                    ST_NO_FRAMES: n_no_frames++;
                    default:      n_miss++;
                endcase
            end
            rsp_stall = idle_on ? $urandom_range(0, 7) : 0;
        end
        if (req_ch.valid && req_ch.ready)
        begin
            w.op  = req_ch.operation;
            w.vpn = req_ch.virtual_page;
            w.ppn = req_ch.new_ppn;
            expected_rsps.push_back(predict_walk(w));
            req_busy = 1'b0;
        end
    end

    initial
    begin
        #4ms;
        $display("five_level_page_table_walker regression: fail");
        $finish;
    end

    initial
    begin
        logic [VPN_W-1:0] vpn_hi;
        int unsigned      roll;
        logic [ROOT_W-1:0] root;
        logic [FREE_W-1:0] first_free;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = '0;
        req_ch.virtual_page = '0;
        req_ch.new_ppn      = '0;
        rsp_ch.ready        = 1'b0;
        foreach (page_mem[i])
            page_mem[i] = '0;
        alloc_count = '0;
        root_cfg    = '0;
        free_cfg    = 7'd1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, two full paths, leaf hits/misses, unused opcode
        set_walk_config(6'd0, 7'd1);
        vpn_hi = '1;
        push_walk(OP_QUERY, '0, '0);
        push_walk(OP_UNMAP, '0, '0);
        push_walk(OP_UNUSED, vpn_hi, '1);
        push_walk(OP_MAP, '0, 52'd1000);
        push_walk(OP_QUERY, '0, '0);
        push_walk(OP_MAP, vpn_hi, '1);
        push_walk(OP_QUERY, vpn_hi, '0);
        push_walk(OP_QUERY, vpn_hi ^ 45'd1, '0);
        push_walk(OP_QUERY, {9'd1, 36'd0}, '0);
        push_walk(OP_MAP, 45'h1FF, '0);
        push_walk(OP_QUERY, 45'h1FF, '0);
        push_walk(OP_UNMAP, 45'h1FF, '0);
        push_walk(OP_QUERY, 45'h1FF, '0);
        push_walk(OP_UNMAP, 45'h1FF, '0);
        push_walk(OP_QUERY, '0, PPN_W'({$urandom, $urandom}));
        drain();

        // root on a leaf table: interior entry holds an out-of-range frame
        set_walk_config(6'd4, free_cfg);
        push_walk(OP_QUERY, '0, '0);
        push_walk(OP_MAP, '0, 52'd7);
        push_walk(OP_UNMAP, '0, '0);
        drain();

        // top root, allocator already past the end
        set_walk_config(6'd63, 7'd64);
        push_walk(OP_MAP, {9'd1, 36'd0}, 52'd5);
        push_walk(OP_QUERY, {9'd1, 36'd0}, '0);
        drain();

        // exhaustion part way down, then resume from frame 0 base
        set_walk_config(6'd0, 7'(62 - alloc_count));
        push_walk(OP_MAP, {9'd2, 36'd0}, 52'd77);
        push_walk(OP_QUERY, {9'd2, 36'd0}, '0);
        drain();
        set_walk_config(6'd0, 7'd0);
        push_walk(OP_MAP, {9'd2, 36'd0}, 52'd77);
        push_walk(OP_QUERY, {9'd2, 36'd0}, '0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            roll = $urandom_range(0, 99);
            root = (phase == 0 || roll < 55) ? 6'd0 : (roll < 65) ? 6'd63 :
                   ROOT_W'($urandom_range(0, NUM_FRAMES - 1));
            roll = $urandom_range(0, 99);
            first_free = (roll < 40) ? 7'd1 : (roll < 55) ? 7'd0 : (roll < 70) ? 7'd64 :
                         FREE_W'($urandom_range(0, NUM_FRAMES));
            set_walk_config(root, first_free);
            idle_on = ($urandom_range(0, 3) != 0);
            queue_random_walks(PHASE_WALKS);
            drain();
        end

        repeat (20) @(negedge clk);
        $display("checked %0d walks: %0d ok, %0d no-mapping, %0d out-of-frames",
                 n_found + n_miss + n_no_frames, n_found, n_miss, n_no_frames);
        $display("table frames handed out by the allocator: %0d", alloc_count);
        if (errors == 0)
            $display("five_level_page_table_walker regression: pass");
        else
            $display("five_level_page_table_walker regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/ptw_pkg.sv
design/ptw_if.sv
design/ptw_frame_ram.sv
design/ptw_walker.sv
design/five_level_page_table_walker.sv
test/five_level_page_table_walker_tb.sv
